### sv/kic_pkg.sv
package kic_pkg;

  localparam int DISPLAY_CHARS_DEF = 12;
  localparam int OUT_CHARS = 12;

  localparam logic [3:0] CODE_MINUS = 4'd10;
  localparam logic [3:0] CODE_BLANK = 4'd15;

  typedef enum logic [3:0] {
    CMD_DIGIT  = 4'd0,
    CMD_CLEAR  = 4'd1,
    CMD_BACK   = 4'd2,
    CMD_NEGATE = 4'd3,
    CMD_POINT  = 4'd4,
    CMD_ADD    = 4'd5,
    CMD_SUB    = 4'd6,
    CMD_MUL    = 4'd7,
    CMD_DIV    = 4'd8,
    CMD_REM    = 4'd9,
    CMD_EQUALS = 4'd10
  } cmd_t;

  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_REM  = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KEY,
    ST_PARSE,
    ST_ARITH,
    ST_ARITH_WAIT,
    ST_CONV,
    ST_CONV_WAIT,
    ST_WRITE,
    ST_FINISH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic key;
    logic parse_start;
    logic parse_step;
    logic arith_start;
    logic arith_step;
    logic conv_start;
    logic conv_step;
    logic write_step;
    logic finish;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    logic need_eval;
    logic parse_done;
    logic arith_done;
    logic conv_done;
    logic write_done;
  } sts_t;

endpackage

### sv/kic_datapath.sv
module kic_datapath #(
  parameter int DISPLAY_CHARS = kic_pkg::DISPLAY_CHARS_DEF
) (
  input  logic               clk,
  input  logic [3:0]         cmd_in,
  input  logic [3:0]         dig_in,
  input  kic_pkg::ctl_t      ctl,
  output kic_pkg::sts_t      sts,
  input  logic               rst,
  output logic [47:0]        o_codes,
  output logic [3:0]         o_len,
  output logic signed [63:0] o_held,
  output logic [2:0]         o_op,
  output logic               o_fresh
);
  localparam int IW = $clog2(DISPLAY_CHARS + 1);
  localparam int CW = $clog2(DISPLAY_CHARS);
  localparam int BW = 4 * DISPLAY_CHARS;
  localparam logic [63:0] DEC_LIMIT = 64'd10 ** DISPLAY_CHARS;

  logic [3:0]  chars [DISPLAY_CHARS];
  logic [IW-1:0] count;
  logic [63:0] prev;
  logic [2:0]  opw;
  logic        fresh;

  logic [3:0]  cmd;

  logic [IW-1:0] idx;
  logic          pneg;
  logic [63:0]   acc;
  logic [63:0]   bval;

  logic [63:0] res;
  logic [63:0] dq;
  logic [63:0] drem;
  logic [63:0] dden;
  logic [6:0]  dcnt;
  logic        na;
  logic        nb;
  logic [63:0] mulp;
  logic [63:0] mcand;
  logic [63:0] mplier;

  logic [63:0] cmag;
  logic [63:0] rmag;
  logic        cneg;
  logic        cbig;
  logic [6:0]  ccnt;
  logic [BW-1:0] bcd;
  logic [BW-1:0] bcd_adj;
  logic [BW-1:0] bcd_next;
  logic [IW-1:0] t;
  logic [IW-1:0] wi;
  logic [IW-1:0] wd;

  logic is_op;
  logic [64:0] dsub;

  function automatic logic [BW-1:0] bcd_adjust(logic [BW-1:0] b);
    logic [BW-1:0] r;
    r = b;
    for (int k = 0; k < DISPLAY_CHARS; k++)
      if (b[4*k +: 4] >= 4'd5) r[4*k +: 4] = b[4*k +: 4] + 4'd3;
    return r;
  endfunction

  function automatic logic [IW-1:0] digit_count(logic [BW-1:0] b, logic wide);
    logic [IW-1:0] n;
    n = IW'(1);
    for (int k = 1; k < DISPLAY_CHARS; k++)
      if (b[4*k +: 4] != 4'd0) n = IW'(k + 1);
    return wide ? IW'(DISPLAY_CHARS) : n;
  endfunction

  assign is_op = (cmd >= kic_pkg::CMD_ADD) && (cmd <= kic_pkg::CMD_REM);
  assign sts.need_eval = (is_op && !fresh && opw != kic_pkg::OP_NONE) ||
                         (cmd == kic_pkg::CMD_EQUALS && opw != kic_pkg::OP_NONE);
  assign sts.parse_done = !(idx < count && idx < IW'(DISPLAY_CHARS) && chars[idx] <= 4'd9);
  assign sts.arith_done = (dcnt == 7'd0);
  assign sts.conv_done = (ccnt == 7'd0);
  assign sts.write_done = !(t != '0 && wi < IW'(DISPLAY_CHARS));

  assign dsub = {1'b0, drem[62:0], dq[63]} - {1'b0, dden};
  assign rmag = res[63] ? 64'd0 - res : res;
  assign bcd_adj = bcd_adjust(bcd);
  assign bcd_next = {bcd_adj[BW-2:0], cmag[63]};
  assign wd = t - IW'(1);

  always_comb begin
    unique case (opw)
      kic_pkg::OP_ADD: res = prev + bval;
      kic_pkg::OP_SUB: res = prev - bval;
      kic_pkg::OP_MUL: res = mulp;
      kic_pkg::OP_DIV: res = (bval == 0) ? 64'd0 : ((na != nb) ? 64'd0 - dq : dq);
      kic_pkg::OP_REM: res = (bval == 0) ? 64'd0 : (na ? 64'd0 - drem : drem);
      default:         res = bval;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DISPLAY_CHARS; i++) chars[i] <= 4'd0;
      count <= IW'(1);
      prev <= '0;
      opw <= kic_pkg::OP_NONE;
      fresh <= 1'b1;
    end else begin
      if (ctl.key) begin
        cmd <= cmd_in;
      end
      if (ctl.parse_start) begin
        acc <= '0;
        if (count != '0 && chars[0] == kic_pkg::CODE_MINUS) begin
          pneg <= 1'b1;
          idx <= IW'(1);
        end else begin
          pneg <= 1'b0;
          idx <= '0;
        end
      end
      if (ctl.parse_step) begin
        acc <= (acc << 3) + (acc << 1) + 64'(chars[idx]);
        idx <= idx + IW'(1);
      end
      if (ctl.arith_start) begin
        bval <= pneg ? 64'd0 - acc : acc;
        na <= prev[63];
        dq <= prev[63] ? 64'd0 - prev : prev;
        drem <= '0;
        dden <= '0;
        dcnt <= 7'd65;
      end
      if (ctl.arith_step) begin
        if (dcnt == 7'd65) begin
          dden <= bval[63] ? 64'd0 - bval : bval;
          nb <= bval[63];
          mcand <= prev;
          mplier <= bval;
          mulp <= '0;
          dcnt <= 7'd64;
        end else begin
          if (!dsub[64]) begin
            drem <= dsub[63:0];
            dq <= {dq[62:0], 1'b1};
          end else begin
            drem <= {drem[62:0], dq[63]};
            dq <= {dq[62:0], 1'b0};
          end
          if (mplier[0]) mulp <= mulp + mcand;
          mcand <= {mcand[62:0], 1'b0};
          mplier <= {1'b0, mplier[63:1]};
          dcnt <= dcnt - 7'd1;
        end
      end
      if (ctl.conv_start) begin
        cneg <= res[63];
        cmag <= rmag;
        cbig <= (rmag >= DEC_LIMIT);
        bcd <= '0;
        ccnt <= 7'd64;
        t <= IW'(1);
        if (cmd != kic_pkg::CMD_EQUALS) begin
          prev <= res;
        end
        wi <= '0;
      end
      if (ctl.conv_step) begin
        bcd <= bcd_next;
        cmag <= {cmag[62:0], 1'b0};
        t <= digit_count(bcd_next, cbig);
        ccnt <= ccnt - 7'd1;
      end
      if (ctl.write_step) begin
        if (wi == '0 && cneg) begin
          chars[0] <= kic_pkg::CODE_MINUS;
          cneg <= 1'b0;
          wi <= IW'(1);
        end else begin
          chars[wi[CW-1:0]] <= bcd[{wd, 2'b00} +: 4];
          t <= t - IW'(1);
          wi <= wi + IW'(1);
        end
      end
      if (ctl.finish) begin
        if (is_op) begin
          if (!sts.need_eval)
            prev <= pneg ? 64'd0 - acc : acc;
          opw <= 3'(cmd - kic_pkg::CMD_POINT);
          fresh <= 1'b1;
        end
        if (cmd == kic_pkg::CMD_EQUALS && sts.need_eval) begin
          prev <= '0;
          opw <= kic_pkg::OP_NONE;
          fresh <= 1'b1;
        end
        if (sts.need_eval)
          count <= wi;
      end
      if (ctl.key && !ctl.finish) begin
        priority case (cmd_in)
          kic_pkg::CMD_DIGIT: begin
            if (dig_in <= 4'd9) begin
              if (fresh) begin
                chars[0] <= dig_in;
                count <= IW'(1);
                fresh <= 1'b0;
              end else if (count == IW'(1) && chars[0] == 4'd0) begin
                chars[0] <= dig_in;
              end else if (count < IW'(DISPLAY_CHARS)) begin
                chars[count[CW-1:0]] <= dig_in;
                count <= count + IW'(1);
              end
            end
          end
          kic_pkg::CMD_CLEAR: begin
            chars[0] <= 4'd0;
            count <= IW'(1);
            prev <= '0;
            opw <= kic_pkg::OP_NONE;
            fresh <= 1'b1;
          end
          kic_pkg::CMD_BACK: begin
            if (count > IW'(1)) begin
              count <= count - IW'(1);
            end else begin
              chars[0] <= 4'd0;
              count <= IW'(1);
            end
          end
          kic_pkg::CMD_NEGATE: begin
            if (count != '0 && chars[0] == kic_pkg::CODE_MINUS) begin
              for (int i = 0; i < DISPLAY_CHARS - 1; i++)
                if (IW'(i + 1) < count) chars[i] <= chars[i + 1];
              count <= count - IW'(1);
            end else if (!(count == IW'(1) && chars[0] == 4'd0) &&
                         count < IW'(DISPLAY_CHARS)) begin
              for (int i = 1; i < DISPLAY_CHARS; i++)
                if (IW'(i) <= count) chars[i] <= chars[i - 1];
              chars[0] <= kic_pkg::CODE_MINUS;
              count <= count + IW'(1);
            end
          end
          default: begin
          end
        endcase
      end
      if (ctl.out_load) begin
        for (int i = 0; i < kic_pkg::OUT_CHARS; i++)
          o_codes[4*i +: 4] <= (i < DISPLAY_CHARS && IW'(i) < count) ? chars[i]
                               : kic_pkg::CODE_BLANK;
        o_len <= 4'(count);
        o_held <= prev;
        o_op <= opw;
        o_fresh <= fresh;
      end
    end
  end
endmodule

### sv/kic_control.sv
module kic_control (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output kic_pkg::ctl_t  ctl,
  input  kic_pkg::sts_t  sts
);
  kic_pkg::state_t state, state_next;
  logic ovalid, ovalid_next;

  assign in_ready = (state == kic_pkg::ST_IDLE);
  assign out_valid = ovalid;

  always_comb begin
    state_next = state;
    unique case (state)
      kic_pkg::ST_IDLE:   if (in_valid) state_next = kic_pkg::ST_KEY;
      kic_pkg::ST_KEY:    state_next = kic_pkg::ST_PARSE;
      kic_pkg::ST_PARSE:  if (sts.parse_done) state_next = kic_pkg::ST_ARITH;
      kic_pkg::ST_ARITH:  state_next = sts.need_eval ? kic_pkg::ST_ARITH_WAIT
                                                     : kic_pkg::ST_FINISH;
      kic_pkg::ST_ARITH_WAIT: if (sts.arith_done) state_next = kic_pkg::ST_CONV;
      kic_pkg::ST_CONV:   state_next = kic_pkg::ST_CONV_WAIT;
      kic_pkg::ST_CONV_WAIT: if (sts.conv_done) state_next = kic_pkg::ST_WRITE;
      kic_pkg::ST_WRITE:  if (sts.write_done) state_next = kic_pkg::ST_FINISH;
      kic_pkg::ST_FINISH: state_next = kic_pkg::ST_OUT;
      kic_pkg::ST_OUT:    if (!ovalid || out_ready) state_next = kic_pkg::ST_IDLE;
      default:            state_next = kic_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    ovalid_next = ovalid && !out_ready;
    unique case (state)
      kic_pkg::ST_IDLE:       ctl.key = in_valid;
      kic_pkg::ST_KEY:        ctl.parse_start = 1'b1;
      kic_pkg::ST_PARSE:      ctl.parse_step = !sts.parse_done;
      kic_pkg::ST_ARITH:      ctl.arith_start = 1'b1;
      kic_pkg::ST_ARITH_WAIT: ctl.arith_step = !sts.arith_done;
      kic_pkg::ST_CONV:       ctl.conv_start = 1'b1;
      kic_pkg::ST_CONV_WAIT:  ctl.conv_step = !sts.conv_done;
      kic_pkg::ST_WRITE:      ctl.write_step = !sts.write_done;
      kic_pkg::ST_FINISH:     ctl.finish = 1'b1;
      kic_pkg::ST_OUT: begin
        if (!ovalid || out_ready) begin
          ctl.out_load = 1'b1;
          ovalid_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kic_pkg::ST_IDLE;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      ovalid <= ovalid_next;
    end
  end
endmodule

### sv/keypad_integer_calculator.sv
// Takes one key press per word and returns one display snapshot per word; the next
// key is taken only after the snapshot has been loaded into the output register. A
// key that applies a waiting operator runs the shared shift-and-subtract divider
// and shift-and-add multiplier, then binary to decimal conversion and write-back
// of the result digits; the two 64-step loops dominate its run time. A snapshot
// not yet taken holds the next one in the output stage.
module keypad_integer_calculator #(
  parameter int DISPLAY_CHARS = kic_pkg::DISPLAY_CHARS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         command,
  input  logic [3:0]         digit,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [47:0]        display_codes,
  output logic [3:0]         display_length,
  output logic signed [63:0] held_value,
  output logic [2:0]         pending_operator,
  output logic               entry_fresh
);
  kic_pkg::ctl_t ctl;
  kic_pkg::sts_t sts;

  kic_control u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .ctl(ctl), .sts(sts)
  );

  kic_datapath #(.DISPLAY_CHARS(DISPLAY_CHARS)) u_dp (
    .clk(clk), .cmd_in(command), .dig_in(digit), .ctl(ctl), .sts(sts),
    .rst(rst), .o_codes(display_codes), .o_len(display_length),
    .o_held(held_value), .o_op(pending_operator), .o_fresh(entry_fresh)
  );
endmodule
